/* hdl/hdng_pkg.sv */
// Shared types, constants and the character-to-slot decode for the n-gram text encoder.
// Depends on nothing; hd_ngram_text_encoder takes what it uses from here by scoped name.
`timescale 1ns / 1ps

package hdng_pkg;

  localparam int HV_DIM_DEF    = 64;
  localparam int MAX_NGRAM_DEF = 8;
  localparam int SUM_WIDTH_DEF = 24;

  localparam int ITEM_COUNT    = 27;
  localparam int SLOT_W        = 5;
  localparam int SPACE_SLOT    = 26;
  localparam int NGRAM_W       = 4;
  localparam logic [NGRAM_W-1:0] NGRAM_RESET = 4'd4;
  localparam logic [NGRAM_W-1:0] NGRAM_MIN   = 4'd2;

  typedef enum logic [0:0] {
    REQ_LOAD = 1'b0,
    REQ_CHAR = 1'b1
  } req_type_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } item_sel_t;

  // Letters a-z map to slots 0..25 and space to the last slot; every other byte misses.
  function automatic item_sel_t char_slot(input logic [7:0] c);
    item_sel_t r;
    r.hit  = 1'b0;
    r.slot = '0;
    if (c inside {[8'h61:8'h7A]}) begin
      r.hit  = 1'b1;
      r.slot = SLOT_W'(c - 8'h61);
    end else if (c == 8'h20) begin
      r.hit  = 1'b1;
      r.slot = SLOT_W'(SPACE_SLOT);
    end
    return r;
  endfunction

endpackage

/* hdl/hd_ngram_text_encoder.sv */
// A character has its item memory read registered on accept; history and sums update as
// it retires, and a last one also loads the output register, which holds it off while full.
// Throughput: one word per cycle, loads and characters alike, unless a last character
// waits for the output; the single item memory read port and the history update set it.
// Reset (rst, synchronous) clears history, fill bits, sum counters, count, saturation flag,
// both valid stages and sets ngram_length to 4; the item memory is not cleared.
// Depends on hdng_pkg.
`timescale 1ns / 1ps

module hd_ngram_text_encoder #(
  parameter int HV_DIM    = hdng_pkg::HV_DIM_DEF,
  parameter int MAX_NGRAM = hdng_pkg::MAX_NGRAM_DEF,
  parameter int SUM_WIDTH = hdng_pkg::SUM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hdng_pkg::NGRAM_W-1:0] cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [hdng_pkg::SLOT_W-1:0]  item_index,
  input  logic [63:0]                  item_vector,
  input  logic [7:0]                   char_code,
  input  logic                         is_last,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [63:0]                  text_hypervector,
  output logic                         any_saturated
);

  localparam int CW = $clog2(MAX_NGRAM + 1);
  localparam int RW = $clog2(MAX_NGRAM);
  localparam logic signed [SUM_WIDTH-1:0] SUM_HI      = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_LO      = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_NEAR_HI = SUM_HI - SUM_WIDTH'(1);
  localparam logic signed [SUM_WIDTH-1:0] SUM_NEAR_LO = SUM_LO + SUM_WIDTH'(1);

  logic [hdng_pkg::NGRAM_W-1:0] ngram_length;

  logic [HV_DIM-1:0]            item_mem [hdng_pkg::ITEM_COUNT];
  logic [HV_DIM-1:0]            rd_data;

  logic                         s1_valid;
  logic                         s1_alpha;
  logic                         s1_last;
  logic                         s1_go;

  logic [HV_DIM-1:0]            hist [MAX_NGRAM];
  logic [MAX_NGRAM-1:0]         filled;
  logic signed [SUM_WIDTH-1:0]  sums [HV_DIM];
  logic [CW-1:0]                chars_seen;
  logic                         sat;

  logic [HV_DIM-1:0]            rows_next [MAX_NGRAM];
  logic [MAX_NGRAM-1:0]         filled_next;
  logic signed [SUM_WIDTH-1:0]  sums_next [HV_DIM];
  logic                         sat_next;
  logic [CW-1:0]                chars_next;
  logic [CW-1:0]                n_act;
  logic [RW-1:0]                last_row;
  logic [HV_DIM-1:0]            rot_last;
  logic [HV_DIM-1:0]            parity;
  logic [HV_DIM-1:0]            prod;
  logic                         all_filled;
  logic                         do_add;
  logic [63:0]                  hv_next;

  logic                         in_acc;
  logic                         char_acc;
  hdng_pkg::item_sel_t          sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ngram_length <= hdng_pkg::NGRAM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ngram_length <= cfg_data;
    end
  end

  assign in_acc   = in_valid && in_ready;
  assign char_acc = in_acc && (req_type == hdng_pkg::REQ_CHAR);
  assign sel      = hdng_pkg::char_slot(char_code);

  // A load writes at its accept edge, so a character right behind it already reads the
  // new vector: no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (in_acc && (req_type == hdng_pkg::REQ_LOAD) &&
        (item_index < hdng_pkg::SLOT_W'(hdng_pkg::ITEM_COUNT))) begin
      item_mem[item_index] <= item_vector[HV_DIM-1:0];
    end
    if (char_acc && sel.hit) begin
      rd_data <= item_mem[sel.slot];
    end
  end

  // A last character may only retire when the output register can take its word.
  assign s1_go    = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= char_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (char_acc) begin
      s1_alpha <= sel.hit;
      s1_last  <= is_last;
    end
  end

  always_comb begin
    if (ngram_length < hdng_pkg::NGRAM_MIN) begin
      n_act = CW'(2);
    end else if (32'(ngram_length) > MAX_NGRAM) begin
      n_act = CW'(MAX_NGRAM);
    end else begin
      n_act = CW'(ngram_length);
    end
    last_row = RW'(n_act - CW'(1));
  end

  assign rot_last = {hist[last_row][HV_DIM-2:0], hist[last_row][HV_DIM-1]};

  // Active rows shift down by one, the last wrapping to row 0, and each rotates left by one
  // element; a hit character's item vector fills row 0; inactive rows keep their contents.
  always_comb begin
    for (int i = 0; i < MAX_NGRAM; i++) begin
      rows_next[i]   = hist[i];
      filled_next[i] = filled[i];
    end
    rows_next[0]   = rot_last;
    filled_next[0] = filled[last_row];
    for (int i = 1; i < MAX_NGRAM; i++) begin
      if (CW'(i) < n_act) begin
        rows_next[i]   = {hist[i-1][HV_DIM-2:0], hist[i-1][HV_DIM-1]};
        filled_next[i] = filled[i-1];
      end
    end
    if (s1_alpha) begin
      rows_next[0]   = rd_data;
      filled_next[0] = 1'b1;
    end
  end

  always_comb begin
    parity     = '0;
    all_filled = 1'b1;
    for (int i = 0; i < MAX_NGRAM; i++) begin
      if (CW'(i) < n_act) begin
        parity = parity ^ ~rows_next[i];
        if (!filled_next[i]) begin
          all_filled = 1'b0;
        end
      end
    end
    prod   = ~parity;
    do_add = (chars_seen >= n_act) && all_filled;
  end

  always_comb begin
    sat_next = sat;
    for (int j = 0; j < HV_DIM; j++) begin
      sums_next[j] = sums[j];
      if (do_add) begin
        if (prod[j]) begin
          if (sums[j] >= SUM_NEAR_HI) begin
            sums_next[j] = SUM_HI;
            sat_next     = 1'b1;
          end else begin
            sums_next[j] = sums[j] + SUM_WIDTH'(1);
          end
        end else begin
          if (sums[j] <= SUM_NEAR_LO) begin
            sums_next[j] = SUM_LO;
            sat_next     = 1'b1;
          end else begin
            sums_next[j] = sums[j] - SUM_WIDTH'(1);
          end
        end
      end
    end
    chars_next = (chars_seen < CW'(MAX_NGRAM)) ? chars_seen + CW'(1) : chars_seen;
  end

  always_comb begin
    hv_next = '0;
    for (int j = 0; j < HV_DIM; j++) begin
      hv_next[j] = !sums_next[j][SUM_WIDTH-1] && (|sums_next[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_go && s1_last)) begin
      for (int i = 0; i < MAX_NGRAM; i++) begin
        hist[i] <= '0;
      end
      for (int j = 0; j < HV_DIM; j++) begin
        sums[j] <= '0;
      end
      filled     <= '0;
      chars_seen <= '0;
      sat        <= 1'b0;
    end else if (s1_go) begin
      for (int i = 0; i < MAX_NGRAM; i++) begin
        hist[i] <= rows_next[i];
      end
      for (int j = 0; j < HV_DIM; j++) begin
        sums[j] <= sums_next[j];
      end
      filled     <= filled_next;
      chars_seen <= chars_next;
      sat        <= sat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      text_hypervector <= hv_next;
      any_saturated    <= sat_next;
    end
  end

`ifndef NO_ASSERTIONS
  // After a text closes, the next character starts from an empty history.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (chars_seen == '0) && (filled == '0) && !sat)
    else $error("history not cleared after last character");

  // A finished word never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |-> (!out_valid || out_ready))
    else $error("result word overwritten");

  // The input side only stalls behind a blocked last character.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s1_last && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // The character count saturates at the longest n-gram.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(chars_seen) <= MAX_NGRAM)
    else $error("character count out of range");

  // The saturation flag and character count only move when a character retires.
  a_sums_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(s1_go) |-> $stable(sat) && $stable(chars_seen))
    else $error("text state changed without a retiring character");
`endif

endmodule

/* verif/tb_hd_ngram_text_encoder.sv */
// Self-checking testbench for hd_ngram_text_encoder: item loads, text streams over several
// n-gram lengths, random input bursts and output stalls, each text vector checked on arrival.
// Depends on hdng_pkg and the hd_ngram_text_encoder RTL.
`timescale 1ns / 1ps

module tb_hd_ngram_text_encoder;

  localparam int HV          = hdng_pkg::HV_DIM_DEF;
  localparam int ROWS        = hdng_pkg::MAX_NGRAM_DEF;
  localparam int SUM_W       = hdng_pkg::SUM_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 250;
  localparam int PHASE_WORDS = 45;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct {
    hdng_pkg::req_type_t         kind;
    logic [hdng_pkg::SLOT_W-1:0] slot;
    logic [HV-1:0]               vec;
    logic [7:0]                  code;
    logic                        last;
  } enc_word_t;

  typedef struct {
    logic [HV-1:0] hv;
    logic          sat;
  } text_result_t;

  logic                         clk;
  logic                         rst         = 1'b1;
  logic                         cfg_valid   = 1'b0;
  logic                         cfg_ready;
  logic [hdng_pkg::NGRAM_W-1:0] cfg_data    = hdng_pkg::NGRAM_RESET;
  logic                         in_valid    = 1'b0;
  logic                         in_ready;
  logic                         req_type    = 1'b0;
  logic [hdng_pkg::SLOT_W-1:0]  item_index  = '0;
  logic [63:0]                  item_vector = '0;
  logic [7:0]                   char_code   = '0;
  logic                         is_last     = 1'b0;
  logic                         out_valid;
  logic                         out_ready   = 1'b0;
  logic [63:0]                  text_hypervector;
  logic                         any_saturated;

  hd_ngram_text_encoder u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .item_index       (item_index),
    .item_vector      (item_vector),
    .char_code        (char_code),
    .is_last          (is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .text_hypervector (text_hypervector),
    .any_saturated    (any_saturated)
  );

  // Encoder state as the testbench sees it.
  logic [HV-1:0]      item_mem_m [hdng_pkg::ITEM_COUNT] = '{default: '0};
  logic [HV-1:0]      hist_m     [ROWS]       = '{default: '0};
  logic               hist_full  [ROWS]       = '{default: 1'b0};
  int                 tally_m    [HV]         = '{default: 0};
  int                 grams_seen = 0;
  logic               sat_seen   = 1'b0;
  logic [hdng_pkg::NGRAM_W-1:0] ngram_set = hdng_pkg::NGRAM_RESET;

  enc_word_t    pending_q [$];
  text_result_t text_vec_q [$];
  enc_word_t    cur_word;

  int   errors = 0, texts_checked = 0, chars_done = 0, loads_done = 0;
  int   words_queued = 0, settings_used = 0, cycles = 0;
  int   gap_left = 0, burst_left = 0;
  int   hold_left = 0, pat_age = 0;
  logic hold_done = 1'b0, stress_armed = 1'b0;
  logic [15:0] stall_pat = '1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic clear_text();
    hist_m     = '{default: '0};
    hist_full  = '{default: 1'b0};
    tally_m    = '{default: 0};
    grams_seen = 0;
    sat_seen   = 1'b0;
  endtask

  // Applies one accepted word to the encoder state and queues the text vector it closes.
  task automatic encode_word(input enc_word_t w);
    int            n, src, s;
    int            hi, lo;
    logic [HV-1:0] rows_nx [ROWS];
    logic          full_nx [ROWS];
    logic          all_full, hit;
    logic [hdng_pkg::SLOT_W-1:0] slot;
    logic [HV-1:0] odd_minus, prod, hv;
    text_result_t  r;
    if (w.kind == hdng_pkg::REQ_LOAD) begin
      loads_done++;
      if (w.slot < hdng_pkg::ITEM_COUNT) item_mem_m[w.slot] = w.vec;
      return;
    end
    chars_done++;
    n = int'(ngram_set);
    if (n < 2) n = 2;
    if (n > ROWS) n = ROWS;
    for (int i = 0; i < n; i++) begin
      src = (i == 0) ? n - 1 : i - 1;
      rows_nx[i] = {hist_m[src][HV-2:0], hist_m[src][HV-1]};
      full_nx[i] = hist_full[src];
    end
    hit  = 1'b0;
    slot = '0;
    if (w.code >= CH_A && w.code <= CH_Z) begin
      hit  = 1'b1;
      slot = hdng_pkg::SLOT_W'(w.code - CH_A);
    end else if (w.code == CH_SPACE) begin
      hit  = 1'b1;
      slot = hdng_pkg::SLOT_W'(hdng_pkg::SPACE_SLOT);
    end
    if (hit) begin
      rows_nx[0] = item_mem_m[slot];
      full_nx[0] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      hist_m[i]    = rows_nx[i];
      hist_full[i] = full_nx[i];
    end
    if (grams_seen >= n) begin
      all_full  = 1'b1;
      odd_minus = '0;
      for (int i = 0; i < n; i++) begin
        if (!hist_full[i]) all_full = 1'b0;
        odd_minus ^= ~hist_m[i];
      end
      if (all_full) begin
        prod = ~odd_minus;
        hi   = (1 << (SUM_W - 1)) - 1;
        lo   = -hi - 1;
        for (int j = 0; j < HV; j++) begin
          s = tally_m[j] + (prod[j] ? 1 : -1);
          if (s >= hi) begin
            s = hi;
            sat_seen = 1'b1;
          end
          if (s <= lo) begin
            s = lo;
            sat_seen = 1'b1;
          end
          tally_m[j] = s;
        end
      end
    end
    if (grams_seen < ROWS) grams_seen++;
    if (w.last) begin
      for (int j = 0; j < HV; j++) hv[j] = tally_m[j] > 0;
      r.hv  = hv;
      r.sat = sat_seen;
      text_vec_q.push_back(r);
      clear_text();
    end
  endtask

  // Sender: bursts of random length with random gaps, fed from pending_q.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) ngram_set = cfg_data;
      if (in_valid && in_ready) encode_word(cur_word);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_word = pending_q.pop_front();
          in_valid    <= 1'b1;
          req_type    <= cur_word.kind;
          item_index  <= cur_word.slot;
          item_vector <= cur_word.vec;
          char_code   <= cur_word.code;
          is_last     <= cur_word.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off once random traffic starts, otherwise a rotating stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stress_armed && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
      out_ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age   = 48;
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
      end
      pat_age--;
      out_ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  always @(posedge clk) begin
    text_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (text_vec_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected text vector, expected none, actual %h sat %b",
                 $time, text_hypervector, any_saturated);
      end else begin
        want = text_vec_q.pop_front();
        texts_checked++;
        if (text_hypervector !== want.hv) begin
          errors++;
          $display("%0t: text_hypervector mismatch, expected %h, actual %h",
                   $time, want.hv, text_hypervector);
        end
        if (any_saturated !== want.sat) begin
          errors++;
          $display("%0t: any_saturated mismatch, expected %b, actual %b",
                   $time, want.sat, any_saturated);
        end
      end
    end
  end

  task automatic push_load(input int slot, input logic [HV-1:0] vec, input logic last);
    enc_word_t w;
    w.kind = hdng_pkg::REQ_LOAD;
    w.slot = hdng_pkg::SLOT_W'(slot);
    w.vec  = vec;
    w.code = 8'($urandom);
    w.last = last;
    pending_q.push_back(w);
    if (slot < hdng_pkg::ITEM_COUNT) words_queued++;
  endtask

  task automatic push_char(input logic [7:0] code, input logic last);
    enc_word_t w;
    w.kind = hdng_pkg::REQ_CHAR;
    w.slot = hdng_pkg::SLOT_W'($urandom);
    w.vec  = {$urandom, $urandom};
    w.code = code;
    w.last = last;
    pending_q.push_back(w);
    words_queued++;
  endtask

  function automatic logic [7:0] pick_char();
    int s;
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    s = $urandom_range(0, hdng_pkg::ITEM_COUNT - 1);
    return (s == hdng_pkg::SPACE_SLOT) ? CH_SPACE : CH_A + 8'(s);
  endfunction

  // One text: mostly a few n-grams long, now and then long enough to pin the count limit.
  task automatic gen_text(input int n_act);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 2 * n_act + 2);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_load(($urandom_range(0, 5) == 0) ? $urandom_range(hdng_pkg::ITEM_COUNT, 31)
                                              : $urandom_range(0, hdng_pkg::ITEM_COUNT - 1),
                  {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      push_char(pick_char(), i == len - 1);
    end
  endtask

  task automatic write_ngram(input logic [hdng_pkg::NGRAM_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Waits until every queued word is in and every text vector is out.
  task automatic wait_quiet();
    while (pending_q.size() != 0 || in_valid || text_vec_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int ngram_plan [$];
    int n_act, start;
    ngram_plan = '{2, 8, 0, 15, 1, 9, 3};
    ngram_plan.push_back($urandom_range(0, 15));
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed texts at the reset n-gram length, touching only slots loaded here.
    push_load(0, '1, 1'b0);
    push_load(25, '0, 1'b0);
    push_load(hdng_pkg::SPACE_SLOT, {$urandom, $urandom}, 1'b0);
    push_load(1, 64'hA5A5_0F0F_3C3C_FF00, 1'b1);
    push_load(hdng_pkg::ITEM_COUNT, {$urandom, $urandom}, 1'b0);
    push_load(31, '1, 1'b1);
    push_char(CH_A, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(CH_A + 8'd1, 1'b0);
    push_char(CH_Z, 1'b0);
    push_char(CH_SPACE, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(CH_A, 1'b0);
    push_char(CH_A + 8'd1, 1'b0);
    push_char(CH_A, 1'b1);
    push_char(CH_Z + 8'd1, 1'b0);
    push_char(CH_A, 1'b0);
    push_char(CH_A - 8'd1, 1'b0);
    push_char(CH_Z, 1'b1);
    push_char(CH_Z, 1'b1);
    wait_quiet();

    foreach (ngram_plan[p]) begin
      write_ngram(hdng_pkg::NGRAM_W'(ngram_plan[p]));
      n_act = ngram_plan[p] < 2 ? 2 : (ngram_plan[p] > ROWS ? ROWS : ngram_plan[p]);
      if (p == 0) begin
        stress_armed = 1'b1;
        for (int k = 0; k < hdng_pkg::ITEM_COUNT; k++) begin
          push_load(k, {$urandom, $urandom}, 1'b0);
        end
      end
      start = words_queued;
      while (words_queued - start < PHASE_WORDS) gen_text(n_act);
      wait_quiet();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d character words and %0d load words over %0d n-gram settings,",
             chars_done, loads_done, settings_used + 1);
    $display("with %0d text vectors compared and %0d mismatches.", texts_checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/hdng_pkg.sv
hdl/hd_ngram_text_encoder.sv
verif/tb_hd_ngram_text_encoder.sv
